// File: rtl/bist_pkg.sv
// Shared types and constants for the bounded integer set table.
`timescale 1ns / 1ps

package bist_pkg;

  localparam int DEF_MAX_ENTRIES = 16;
  localparam int DATA_W          = 32;
  localparam int CAP_W           = 5;
  localparam int POS_W           = 8;
  localparam int OUT_CNT_W       = 5;
  // Cell index and count fields of the broadcast word cover the largest store.
  localparam int IDX_W           = 8;
  localparam int BC_CNT_W        = 9;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_MEMBER = 2'd2,
    OP_GET    = 2'd3
  } op_t;

  // Control word broadcast from the sequencer to every cell.
  typedef struct packed {
    logic [DATA_W-1:0]   value;
    logic [BC_CNT_W-1:0] count;
    logic [IDX_W-1:0]    rd_idx;
    logic [IDX_W-1:0]    ins_idx;
    logic                ins_en;
    logic                rm_en;
  } bcast_t;

endpackage

// File: rtl/bounded_integer_set_table.sv
// Top level of the bounded integer set table: sequencer, count and a row of entry cells.
// Busy is high in the cycle after the accepting edge of start, and the result strobe
// is high in the cycle after that. A new word is taken only while idle; busy is high
// for the one evaluate cycle, in which the row of cells compares, reads and writes in
// a single pass.
// Reset (rst_n low, synchronous) empties the set and sets the capacity to 16; entries are
// not cleared. The receiver cannot stall, so results never wait.
`timescale 1ns / 1ps

module bounded_integer_set_table #(
  parameter int MAX_ENTRIES = bist_pkg::DEF_MAX_ENTRIES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_operation,
  input  logic signed [bist_pkg::DATA_W-1:0] in_value,
  input  logic [bist_pkg::POS_W-1:0]     in_position,
  output logic                           out_strobe,
  output logic                           out_success,
  output logic                           out_bad_position,
  output logic signed [bist_pkg::DATA_W-1:0] out_read_value,
  output logic [bist_pkg::OUT_CNT_W-1:0] out_entry_count,
  input  logic                           cfg_we,
  input  logic [bist_pkg::CAP_W-1:0]     cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  // Compares run wide enough for the count, the capacity and the full get position.
  localparam int CMP_A = (CNT_W > bist_pkg::CAP_W) ? CNT_W : bist_pkg::CAP_W;
  localparam int CMP_W = (CMP_A > bist_pkg::POS_W) ? CMP_A : bist_pkg::POS_W;

  typedef enum logic {S_IDLE, S_EVAL} state_t;

  state_t                        state_r;
  logic [bist_pkg::CAP_W-1:0]    cap_r;
  logic [CNT_W-1:0]              count_r;
  logic [CNT_W-1:0]              count_nxt;
  bist_pkg::op_t                 op_r;
  logic [bist_pkg::DATA_W-1:0]   value_r;
  logic [bist_pkg::POS_W-1:0]    pos_r;

  logic [CMP_W-1:0]              count_ext;
  logic [CMP_W-1:0]              cap_ext;
  logic [CMP_W-1:0]              max_ext;
  logic [CMP_W-1:0]              eff_cap;
  logic [CMP_W-1:0]              pos_ext;
  logic [CMP_W-1:0]              count_nxt_ext;
  logic                          evaluating;
  logic                          found;
  logic                          room;
  logic                          pos_ok;
  logic                          success_nxt;
  logic [bist_pkg::DATA_W-1:0]   chain_rd;
  bist_pkg::bcast_t              bc;

  logic [MAX_ENTRIES:0]          hit_c;
  logic [bist_pkg::DATA_W-1:0]   rd_c [MAX_ENTRIES+1];

  assign busy       = (state_r == S_EVAL);
  assign evaluating = (state_r == S_EVAL);

  assign count_ext = CMP_W'(count_r);
  assign cap_ext   = CMP_W'(cap_r);
  assign max_ext   = CMP_W'(MAX_ENTRIES);
  assign eff_cap   = (cap_ext > max_ext) ? max_ext : cap_ext;
  assign pos_ext   = CMP_W'(pos_r);
  assign room      = count_ext < eff_cap;
  assign pos_ok    = pos_ext < count_ext;

  assign hit_c[0] = 1'b0;
  assign rd_c[0]  = '0;
  assign found    = hit_c[MAX_ENTRIES];
  assign chain_rd = rd_c[MAX_ENTRIES];

  // A get reads the requested slot; every other operation reads the last live slot.
  always_comb begin
    bc.value   = value_r;
    bc.count   = bist_pkg::BC_CNT_W'(count_r);
    bc.rd_idx  = (op_r == bist_pkg::OP_GET) ? pos_r
                                            : bist_pkg::IDX_W'(count_r - CNT_W'(1));
    bc.ins_idx = bist_pkg::IDX_W'(count_r);
    bc.ins_en  = evaluating && (op_r == bist_pkg::OP_INSERT) && room && !found;
    bc.rm_en   = evaluating && (op_r == bist_pkg::OP_REMOVE);
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
      bist_cell #(
        .CELL_IDX (bist_pkg::IDX_W'(gi))
      ) u_cell (
        .clk       (clk),
        .bc        (bc),
        .last_word (chain_rd),
        .hit_in    (hit_c[gi]),
        .hit_out   (hit_c[gi+1]),
        .rd_in     (rd_c[gi]),
        .rd_out    (rd_c[gi+1])
      );
    end
  endgenerate

  always_comb begin
    count_nxt   = count_r;
    success_nxt = 1'b0;
    unique case (op_r)
      bist_pkg::OP_INSERT: begin
        success_nxt = room && !found;
        if (success_nxt) begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      bist_pkg::OP_REMOVE: begin
        success_nxt = found;
        if (found) begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      bist_pkg::OP_MEMBER: success_nxt = found;
      bist_pkg::OP_GET:    success_nxt = pos_ok;
      default:             success_nxt = 1'b0;
    endcase
  end

  assign count_nxt_ext = CMP_W'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      count_r          <= '0;
      cap_r            <= bist_pkg::CAP_RESET;
      out_strobe       <= 1'b0;
      out_success      <= 1'b0;
      out_bad_position <= 1'b0;
      out_read_value   <= '0;
      out_entry_count  <= '0;
    end else begin
      out_strobe <= 1'b0;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r    <= bist_pkg::op_t'(in_operation);
            value_r <= in_value;
            pos_r   <= in_position;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          count_r          <= count_nxt;
          out_strobe       <= 1'b1;
          out_success      <= success_nxt;
          out_bad_position <= (op_r == bist_pkg::OP_GET) && !pos_ok;
          out_read_value   <= ((op_r == bist_pkg::OP_GET) && pos_ok) ? chain_rd : '0;
          out_entry_count  <= count_nxt_ext[bist_pkg::OUT_CNT_W-1:0];
          state_r          <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/bist_cell.sv
// One storage cell of the set: holds one entry, compares it and passes hit and read data on.
`timescale 1ns / 1ps

module bist_cell #(
  parameter logic [bist_pkg::IDX_W-1:0] CELL_IDX = '0
) (
  input  logic                        clk,
  input  bist_pkg::bcast_t            bc,
  input  logic [bist_pkg::DATA_W-1:0] last_word,
  input  logic                        hit_in,
  output logic                        hit_out,
  input  logic [bist_pkg::DATA_W-1:0] rd_in,
  output logic [bist_pkg::DATA_W-1:0] rd_out
);

  logic [bist_pkg::DATA_W-1:0] entry_r;
  logic                        live;
  logic                        match;

  // Only slots below the live count take part in a search.
  assign live    = {1'b0, CELL_IDX} < bc.count;
  assign match   = live && (entry_r == bc.value);
  assign hit_out = hit_in | match;
  assign rd_out  = rd_in | ((CELL_IDX == bc.rd_idx) ? entry_r : '0);

  always_ff @(posedge clk) begin
    if (bc.ins_en && (CELL_IDX == bc.ins_idx)) begin
      entry_r <= bc.value;
    end else if (bc.rm_en && match) begin
      // The last live word fills the hole left by the removed value.
      entry_r <= last_word;
    end
  end

endmodule

// File: rtl/bist_checker.sv
// Port-level checker for the bounded integer set table, bound to the top level.
`timescale 1ns / 1ps

module bist_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_strobe,
  input logic                           out_success,
  input logic                           out_bad_position,
  input logic [bist_pkg::DATA_W-1:0]    out_read_value
);

  // An accepted word makes the block busy for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted word");

  // Every accepted word is followed by a result strobe once its evaluate state is done.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_strobe)
    else $error("result strobe missing after an accepted word");

  // A result only appears right after a busy cycle.
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_strobe) |-> $past(busy))
    else $error("result strobe without a preceding evaluate cycle");

  // A get at or beyond the count never succeeds and never returns data.
  a_bad_position_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_bad_position) |-> (!out_success && (out_read_value == '0)))
    else $error("get beyond the count reported success or data");

endmodule

bind bounded_integer_set_table bist_checker u_bist_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_strobe       (out_strobe),
  .out_success      (out_success),
  .out_bad_position (out_bad_position),
  .out_read_value   (out_read_value)
);
